// ----- hw/rtl/kslp_pkg.sv -----
`default_nettype none

package kslp_pkg;

    // Field widths fixed by the scan and result formats
    localparam int KEY_FIELD_W = 4;
    localparam int TIME_W      = 32;
    localparam int THRESH_W    = 16;

    // Long-press threshold after reset, in milliseconds
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd2000;

    // Per-key debounce phase; the unused code falls back to idle
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HELD    = 2'd2
    } phase_t;

    // Pulses produced by one key on one scan
    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } kslp_pulse_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kslp_key_fsm.sv -----
`default_nettype none

module kslp_key_fsm
    import kslp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                level,
    input  wire logic [TIME_W-1:0]   now_ms,
    input  wire logic [THRESH_W-1:0] long_press_ms,
    output kslp_pulse_t              pulse
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic                long_done_reg;
    logic                long_done_next;
    logic [TIME_W-1:0]   press_time_reg;
    logic                capture;
    logic [TIME_W-1:0]   elapsed;
    logic                reached;

    // Wrapping elapsed time since the press against the threshold
    assign elapsed = now_ms - press_time_reg;
    assign reached = elapsed >= {{(TIME_W-THRESH_W){1'b0}}, long_press_ms};

    // Next phase
    always_comb
    begin
        case (phase_reg)
            PH_IDLE:    phase_next = level ? PH_IDLE : PH_CONFIRM;
            PH_CONFIRM: phase_next = level ? PH_IDLE : PH_HELD;
            PH_HELD:    phase_next = level ? PH_IDLE : PH_HELD;
            default:    phase_next = PH_IDLE;
        endcase
    end

    // Pulses, press capture and long-press mark
    always_comb
    begin
        pulse          = '0;
        capture        = 1'b0;
        long_done_next = long_done_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!level)
                begin
                    capture        = 1'b1;
                    long_done_next = 1'b0;
                end
            end
            PH_CONFIRM:
            begin
                capture = 1'b0;
            end
            PH_HELD:
            begin
                if (level)
                begin
                    pulse.short_hit = !long_done_reg;
                end
                else if (!long_done_reg && reached)
                begin
                    pulse.long_hit = 1'b1;
                    long_done_next = 1'b1;
                end
            end
            default:
            begin
                capture = 1'b0;
            end
        endcase
    end

    // Advance control state on each accepted scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            long_done_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            long_done_reg <= long_done_next;
        end
    end

    // Hold the press timestamp
    always_ff @(posedge clk)
    begin
        if (advance && capture)
        begin
            press_time_reg <= now_ms;
        end
    end

    a_pulse_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({pulse.short_hit, pulse.long_hit}))
        else $error("short and long press on the same scan");

    a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pulse.long_hit) |=> long_done_reg)
        else $error("long press fired without setting its mark");

    a_press_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_IDLE && !level)
        |=> (press_time_reg == $past(now_ms) && phase_reg == PH_CONFIRM))
        else $error("press not recorded on entry to confirm");

endmodule

`default_nettype wire

// ----- hw/rtl/key_short_long_press_scanner.sv -----
// An accepted scan's result appears on short_press/long_press in the cycle after it is taken.
// Throughput: one scan per cycle; a scan is taken whenever the result register
// is empty or is being drained in the same cycle.
// Reset (rst_n low, asynchronous): every key idle, no result pending,
// long_press_ms back to 2000.
`default_nettype none

module key_short_long_press_scanner
    import kslp_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [THRESH_W-1:0]    cfg_wr_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [KEY_FIELD_W-1:0] key_levels,
    input  wire logic [TIME_W-1:0]      now_ms,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [KEY_FIELD_W-1:0]      short_press,
    output logic [KEY_FIELD_W-1:0]      long_press
);

    localparam int OUT_KEYS = (NUM_KEYS < KEY_FIELD_W) ? NUM_KEYS : KEY_FIELD_W;

    logic [THRESH_W-1:0]    long_press_ms_reg;
    logic                   out_valid_reg;
    logic [KEY_FIELD_W-1:0] short_press_reg;
    logic [KEY_FIELD_W-1:0] long_press_reg;
    logic [KEY_FIELD_W-1:0] short_press_next;
    logic [KEY_FIELD_W-1:0] long_press_next;
    logic                   accept;
    logic [NUM_KEYS-1:0]    levels;
    logic [NUM_KEYS-1:0]    short_vec;
    logic [NUM_KEYS-1:0]    long_vec;

    // Take a scan when the result slot is free or drains this cycle
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ms_reg <= THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            long_press_ms_reg <= cfg_wr_data;
        end
    end

    // One machine per key; keys past the field read as pressed
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        kslp_pulse_t pulse;

        if (k < KEY_FIELD_W)
        begin : g_pin
            assign levels[k] = key_levels[k];
        end
        else
        begin : g_tied
            assign levels[k] = 1'b0;
        end

        kslp_key_fsm u_key (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (accept),
            .level         (levels[k]),
            .now_ms        (now_ms),
            .long_press_ms (long_press_ms_reg),
            .pulse         (pulse)
        );

        assign short_vec[k] = pulse.short_hit;
        assign long_vec[k]  = pulse.long_hit;
    end

    // Drop pulses of keys beyond the result width
    always_comb
    begin
        short_press_next = '0;
        long_press_next  = '0;
        for (int i = 0; i < OUT_KEYS; i++)
        begin
            short_press_next[i] = short_vec[i];
            long_press_next[i]  = long_vec[i];
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            short_press_reg <= short_press_next;
            long_press_reg  <= long_press_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign short_press = short_press_reg;
    assign long_press  = long_press_reg;

    a_scan_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted scan produced no result");

    a_held_result_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(short_press)
                                      && $stable(long_press)))
        else $error("stalled result changed or vanished");

    a_no_double_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((short_press & long_press) == '0))
        else $error("key reports short and long press together");

endmodule

`default_nettype wire
